### hw/rtl/fspf_pkg.sv
// Package for the spectrum peak finder: default sizes, state and code
// enums, and the elaboration-time twiddle generator.
// No dependencies.
`default_nettype none

package fspf_pkg;

  // Default sizes
  localparam int DEF_FFT_POINTS     = 1024;
  localparam int DEF_MAX_FRAME_WORDS = 4096;
  localparam int DEF_TWIDDLE_BITS   = 16;

  localparam longint Q30_ONE = 64'sd1073741824;

  // Request and result codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;
  localparam logic KIND_PEAK  = 1'b0;
  localparam logic KIND_BIN   = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DC_REMOVE,
    REG_SEARCH_START,
    REG_SEARCH_END
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MEAN,
    ST_DIV,
    ST_LOAD,
    ST_FFT,
    ST_MAG_RD,
    ST_MAG_SQ,
    ST_MAG_SUM,
    ST_MAG_ROOT,
    ST_MAG_WR,
    ST_REPORT
  } state_t;

  // Floor square root, one result bit per step
  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Round half up by sh bits (floor of value plus half)
  function automatic longint shr_rnd(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Twiddle k: {cos, sin} of 2*pi*k/N, each 24 bits, sign-extended from tb bits
  function automatic logic [47:0] tw_entry(int k, int lg, int tb);
    longint ang_c [32];
    longint ang_s [32];
    longint x;
    longint y;
    longint nx;
    longint ny;
    longint c;
    longint s;
    longint cq;
    longint sq;
    longint lim;
    lim = (longint'(1) <<< (tb - 1)) - 1;
    for (int j = 0; j < 32; j++) begin
      ang_c[j] = 0;
      ang_s[j] = 0;
    end
    ang_c[1] = -Q30_ONE;
    for (int j = 2; j <= lg; j++) begin
      ang_c[j] = longint'(isqrt64(64'(Q30_ONE + ang_c[j-1]) << 29));
      ang_s[j] = longint'(isqrt64(64'(Q30_ONE - ang_c[j-1]) << 29));
    end
    x = Q30_ONE;
    y = 0;
    for (int b = 0; b < lg; b++) begin
      if (((k >> b) & 1) != 0) begin
        c  = ang_c[lg - b];
        s  = ang_s[lg - b];
        nx = shr_rnd(x * c - y * s, 30);
        ny = shr_rnd(x * s + y * c, 30);
        x  = nx;
        y  = ny;
      end
    end
    cq = shr_rnd(x, 31 - tb);
    sq = shr_rnd(y, 31 - tb);
    if (cq > lim) cq = lim;
    if (cq < -lim) cq = -lim;
    if (sq > lim) sq = lim;
    if (sq < -lim) sq = -lim;
    return {cq[23:0], sq[23:0]};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fft_spectrum_peak_finder.sv
// Spectrum peak finder: sample capture, mean divider, in-place radix-2 FFT
// over dual-read-port memories, magnitude root unit and peak search.
// Depends on fspf_pkg.
//
// Request handling: in_stall holds off requests while the sequencer is not idle.
//   sample word without frame end: accepted with no result; the sequencer stays idle.
//   bin read: result registered from ST_READ once the output register is free.
//   frame end: mean division, bit-reversed load, transform stages, then per-bin
//   magnitude root and peak search before the report; the butterflies share the
//   memory write port, and each bin's square root runs one step per cycle.
// Reset (synchronous): registers to their reset values, sum and count cleared,
// no spectrum held; memories are not cleared and need no clearing pass.
`default_nettype none

module fft_spectrum_peak_finder
  import fspf_pkg::*;
#(
  parameter int FFT_POINTS      = DEF_FFT_POINTS,
  parameter int MAX_FRAME_WORDS = DEF_MAX_FRAME_WORDS,
  parameter int TWIDDLE_BITS    = DEF_TWIDDLE_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [15:0] dma_word,
  input  wire logic        frame_last,
  input  wire logic [11:0] read_bin,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic             peak_found,
  output logic [10:0]      peak_bin,
  output logic [23:0]      peak_magnitude,
  output logic [23:0]      bin_magnitude,
  output logic             bin_valid,
  output logic [15:0]      dc_mean,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int LG      = $clog2(FFT_POINTS);
  localparam int HB      = LG - 1;
  localparam int HALF    = FFT_POINTS / 2;
  localparam int CNT_MAX = 2 * MAX_FRAME_WORDS;
  localparam int CB      = $clog2(CNT_MAX + 1);
  localparam int SB      = CB + 8;
  localparam int DW      = SB + 8;
  localparam int DCB     = $clog2(DW);
  localparam int SGB     = $clog2(LG);
  localparam int XB      = CB + LG;
  localparam int TB      = TWIDDLE_BITS;
  localparam int PW      = 32 + TB;
  localparam int SW      = PW + 1;
  localparam logic signed [SW-1:0] BF_RND = SW'(1) << (TB - 2);

  typedef logic [2*TB-1:0] tw_rom_t [HALF];

  function automatic tw_rom_t build_tw();
    tw_rom_t     rom;
    logic [47:0] e;
    for (int k = 0; k < HALF; k++) begin
      e = tw_entry(k, LG, TB);
      rom[k] = {e[24 +: TB], e[0 +: TB]};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_tw();

  function automatic logic [LG-1:0] bit_rev(logic [LG-1:0] v);
    logic [LG-1:0] r;
    for (int i = 0; i < LG; i++) r[i] = v[LG-1-i];
    return r;
  endfunction

  function automatic logic [31:0] sat32(logic signed [SW-1:0] v);
    if ((&v[SW-1:31]) || (~|v[SW-1:31])) return v[31:0];
    return v[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // ---------------- declarations ----------------
  state_t state, state_next;

  logic        cfg_dc_en;
  logic [11:0] cfg_start;
  logic [11:0] cfg_end;
  logic        cfg_wr;

  logic        in_acc, smp_acc, rd_acc, out_free, out_load;
  logic [CB-1:0] count;
  logic [SB-1:0] sum;
  logic [XB-1:0] cnt_ext;
  logic          cnt_room;

  logic [15:0] smp_mem [HALF];
  logic [15:0] smp_q;

  logic [DW-1:0]  div_num;
  logic [CB-1:0]  div_rem;
  logic [15:0]    div_q;
  logic [DCB-1:0] div_cnt;
  logic [CB:0]    rem_sh;
  logic           div_ge;
  logic [15:0]    dc;

  logic [LG:0]   ld_i;
  logic          ld_v, ld_use;
  logic [LG-1:0] ld_idx;
  logic [7:0]    ld_byte;
  logic [31:0]   ld_x;

  logic [31:0]   re_mem [FFT_POINTS];
  logic [31:0]   im_mem [FFT_POINTS];
  logic [31:0]   re_qa, re_qb, im_qa, im_qb;
  logic [LG-1:0] rd_a_addr, rd_b_addr;
  logic          wr_en;
  logic [LG-1:0] wr_addr;
  logic [31:0]   wr_re, wr_im;

  logic [HB-1:0]  bf_j;
  logic [SGB-1:0] bf_stage;
  logic           bf_phase, bf_wait, bf_issue, bf_done, pipe_empty;
  logic [LG-1:0]  jx, bf_mask, bf_a, bf_b, bf_kx;
  logic [2*TB-1:0] tw_q;

  logic                  v1, v2, v3, vb;
  logic [LG-1:0]         p1_a, p1_b, p2_a, p2_b, p3_a, p3_b, wb_addr;
  logic signed [TB-1:0]  tw_c, tw_s;
  logic signed [31:0]    br, bi;
  logic signed [PW-1:0]  p2_brc, p2_bis, p2_bic, p2_brs;
  logic signed [31:0]    p2_ar, p2_ai, p3_ar, p3_ai;
  logic signed [SW-1:0]  p3_tr, p3_ti;
  logic [31:0]           wb_re, wb_im, a_re_new, a_im_new;

  logic [HB-1:0] mag_i;
  logic [31:0]   abs_re, abs_im;
  logic [63:0]   sq_re, sq_im;
  logic [63:0]   rt_v, rt_r, rt_bit;
  logic [63:0]   rt_m;
  logic [23:0]   mag_w;
  logic [23:0]   mag_mem [HALF];
  logic [23:0]   mag_q;
  logic          rd_ok;
  logic [HB-1:0] start_c, end_c;
  logic          in_rng, found;
  logic [23:0]   best_mag;
  logic [HB-1:0] best_bin;
  logic          best_have;
  logic          spectrum_ready;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_dc_en <= 1'b1;
      cfg_start <= 12'd0;
      cfg_end   <= 12'd511;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_DC_REMOVE:    cfg_dc_en <= pwdata[0];
        REG_SEARCH_START: cfg_start <= pwdata[11:0];
        REG_SEARCH_END:   cfg_end   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_DC_REMOVE:    prdata = {31'd0, cfg_dc_en};
      REG_SEARCH_START: prdata = {20'd0, cfg_start};
      REG_SEARCH_END:   prdata = {20'd0, cfg_end};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------- handshake ----------------
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign smp_acc  = in_acc && (req_type == REQ_SAMPLE);
  assign rd_acc   = in_acc && (req_type == REQ_READ);
  assign out_free = !out_valid || !out_stall;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (rd_acc) state_next = ST_READ;
        else if (smp_acc && frame_last) state_next = ST_MEAN;
      end
      ST_READ:     if (out_free) state_next = ST_IDLE;
      ST_MEAN:     state_next = ST_DIV;
      ST_DIV:      if (div_cnt == DCB'(DW - 1)) state_next = ST_LOAD;
      ST_LOAD:     if (ld_i[LG] && !ld_v) state_next = ST_FFT;
      ST_FFT:      if (bf_done) state_next = ST_MAG_RD;
      ST_MAG_RD:   state_next = ST_MAG_SQ;
      ST_MAG_SQ:   state_next = ST_MAG_SUM;
      ST_MAG_SUM:  state_next = ST_MAG_ROOT;
      ST_MAG_ROOT: if (rt_bit[0]) state_next = ST_MAG_WR;
      ST_MAG_WR:   state_next = (&mag_i) ? ST_REPORT : ST_MAG_RD;
      ST_REPORT:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // ---------------- control outputs ----------------
  always_comb begin
    out_load  = 1'b0;
    bf_issue  = 1'b0;
    rd_a_addr = bf_a;
    case (state)
      ST_READ, ST_REPORT: out_load = out_free;
      ST_FFT:             bf_issue = !bf_wait && !bf_phase;
      ST_MAG_RD:          rd_a_addr = LG'(mag_i);
      default: ;
    endcase
  end

  assign rd_b_addr  = bf_b;
  assign pipe_empty = !(v1 || v2 || v3 || vb);
  assign bf_done    = bf_wait && pipe_empty && (bf_stage == SGB'(LG - 1));

  // ---------------- sample capture ----------------
  assign cnt_ext  = XB'(count);
  assign cnt_room = (32'(count) < 32'(CNT_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
    end else if ((state == ST_REPORT) && out_free) begin
      count <= '0;
      sum   <= '0;
    end else if (smp_acc && cnt_room) begin
      count <= count + CB'(2);
      sum   <= sum + SB'(dma_word[7:0]) + SB'(dma_word[15:8]);
    end
  end

  // Sample word store: one word holds two samples
  always_ff @(posedge clk) begin
    if (smp_acc && cnt_room && (32'(count) < 32'(FFT_POINTS)))
      smp_mem[cnt_ext[LG-1:1]] <= dma_word;
    smp_q <= smp_mem[ld_i[LG-1:1]];
  end

  // ---------------- mean divider ----------------
  assign rem_sh = {div_rem, div_num[DW-1]};
  assign div_ge = (rem_sh >= {1'b0, count});

  always_ff @(posedge clk) begin
    if (state == ST_MEAN) begin
      div_num <= {sum, 8'd0} + DW'(count >> 1);
      div_rem <= '0;
      div_q   <= '0;
      div_cnt <= '0;
    end else if (state == ST_DIV) begin
      div_num <= div_num << 1;
      div_rem <= div_ge ? CB'(rem_sh - {1'b0, count}) : rem_sh[CB-1:0];
      div_q   <= {div_q[14:0], div_ge};
      div_cnt <= div_cnt + DCB'(1);
      if (div_cnt == DCB'(DW - 1))
        dc <= (count == '0) ? 16'd0 : {div_q[14:0], div_ge};
    end
  end

  // ---------------- load pass, bit-reversed ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ld_v <= 1'b0;
      ld_i <= '0;
    end else begin
      ld_v <= (state == ST_LOAD) && !ld_i[LG];
      if (state == ST_MEAN) ld_i <= '0;
      else if ((state == ST_LOAD) && !ld_i[LG]) ld_i <= ld_i + (LG+1)'(1);
    end
    ld_idx <= ld_i[LG-1:0];
    ld_use <= (32'(ld_i) < 32'(count));
  end

  assign ld_byte = ld_idx[0] ? smp_q[15:8] : smp_q[7:0];
  assign ld_x    = ld_use ? ((32'(ld_byte) << 8) - (cfg_dc_en ? 32'(dc) : 32'd0)) : 32'd0;

  // ---------------- butterfly addressing ----------------
  assign jx      = LG'(bf_j);
  assign bf_mask = (LG'(1) << bf_stage) - LG'(1);
  assign bf_a    = (((jx >> bf_stage) << 1) << bf_stage) | (jx & bf_mask);
  assign bf_b    = bf_a | (LG'(1) << bf_stage);
  assign bf_kx   = (jx & bf_mask) << (SGB'(LG - 1) - bf_stage);

  always_ff @(posedge clk) begin
    if (rst) begin
      bf_wait  <= 1'b0;
      bf_phase <= 1'b0;
      bf_stage <= '0;
      bf_j     <= '0;
    end else if (state == ST_MEAN) begin
      bf_wait  <= 1'b0;
      bf_phase <= 1'b0;
      bf_stage <= '0;
      bf_j     <= '0;
    end else if (state == ST_FFT) begin
      if (!bf_wait) bf_phase <= ~bf_phase;
      if (bf_issue) begin
        if (&bf_j) bf_wait <= 1'b1;
        else       bf_j <= bf_j + HB'(1);
      end
      // advance to the next stage once the pipeline has drained
      if (bf_wait && pipe_empty && (bf_stage != SGB'(LG - 1))) begin
        bf_stage <= bf_stage + SGB'(1);
        bf_wait  <= 1'b0;
        bf_phase <= 1'b0;
        bf_j     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tw_q <= TW_ROM[bf_kx[HB-1:0]];
  end

  // ---------------- transform memories ----------------
  always_comb begin
    wr_en   = ld_v || v3 || vb;
    wr_addr = bit_rev(ld_idx);
    wr_re   = ld_x;
    wr_im   = 32'd0;
    if (v3) begin
      wr_addr = p3_a;
      wr_re   = a_re_new;
      wr_im   = a_im_new;
    end else if (vb) begin
      wr_addr = wb_addr;
      wr_re   = wb_re;
      wr_im   = wb_im;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      re_mem[wr_addr] <= wr_re;
      im_mem[wr_addr] <= wr_im;
    end
    re_qa <= re_mem[rd_a_addr];
    im_qa <= im_mem[rd_a_addr];
    re_qb <= re_mem[rd_b_addr];
    im_qb <= im_mem[rd_b_addr];
  end

  // ---------------- butterfly pipeline ----------------
  assign tw_c = tw_q[2*TB-1:TB];
  assign tw_s = tw_q[TB-1:0];
  assign br   = re_qb;
  assign bi   = im_qb;

  assign a_re_new = sat32(SW'(p3_ar) + p3_tr);
  assign a_im_new = sat32(SW'(p3_ai) + p3_ti);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vb <= 1'b0;
    end else begin
      v1 <= bf_issue;
      v2 <= v1;
      v3 <= v2;
      vb <= v3;
    end
    // read data arrives
    p1_a <= bf_a;
    p1_b <= bf_b;
    // products
    p2_brc <= br * tw_c;
    p2_bis <= bi * tw_s;
    p2_bic <= bi * tw_c;
    p2_brs <= br * tw_s;
    p2_ar  <= re_qa;
    p2_ai  <= im_qa;
    p2_a   <= p1_a;
    p2_b   <= p1_b;
    // rounded twiddle product
    p3_tr <= (SW'(p2_brc) + SW'(p2_bis) + BF_RND) >>> (TB - 1);
    p3_ti <= (SW'(p2_bic) - SW'(p2_brs) + BF_RND) >>> (TB - 1);
    p3_ar <= p2_ar;
    p3_ai <= p2_ai;
    p3_a  <= p2_a;
    p3_b  <= p2_b;
    // hold the lower output for the second write cycle
    wb_re   <= sat32(SW'(p3_ar) - p3_tr);
    wb_im   <= sat32(SW'(p3_ai) - p3_ti);
    wb_addr <= p3_b;
  end

  // ---------------- magnitude and peak search ----------------
  assign abs_re  = re_qa[31] ? (32'd0 - re_qa) : re_qa;
  assign abs_im  = im_qa[31] ? (32'd0 - im_qa) : im_qa;
  assign rt_m    = (rt_r + 64'd8) >> 4;
  assign mag_w   = (|rt_m[63:24]) ? 24'hFF_FFFF : rt_m[23:0];
  assign start_c = (32'(cfg_start) >= 32'(HALF)) ? HB'(HALF - 1) : cfg_start[HB-1:0];
  assign end_c   = (32'(cfg_end) >= 32'(HALF)) ? HB'(HALF - 1) : cfg_end[HB-1:0];
  assign in_rng  = (mag_i >= start_c) && (mag_i <= end_c);
  assign found   = (start_c <= end_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_have <= 1'b0;
      mag_i     <= '0;
    end else if (state == ST_MEAN) begin
      best_have <= 1'b0;
      mag_i     <= '0;
    end else if (state == ST_MAG_WR) begin
      mag_i <= mag_i + HB'(1);
      if (in_rng && (!best_have || (mag_w > best_mag))) best_have <= 1'b1;
    end
    if (state == ST_MAG_SQ) begin
      sq_re <= abs_re * abs_re;
      sq_im <= abs_im * abs_im;
    end
    if (state == ST_MAG_SUM) begin
      rt_v   <= sq_re + sq_im;
      rt_r   <= '0;
      rt_bit <= 64'h4000_0000_0000_0000;
    end else if (state == ST_MAG_ROOT) begin
      if (rt_v >= rt_r + rt_bit) begin
        rt_v <= rt_v - (rt_r + rt_bit);
        rt_r <= (rt_r >> 1) + rt_bit;
      end else begin
        rt_r <= rt_r >> 1;
      end
      rt_bit <= rt_bit >> 2;
    end
    if ((state == ST_MAG_WR) && in_rng && (!best_have || (mag_w > best_mag))) begin
      best_mag <= mag_w;
      best_bin <= mag_i;
    end
  end

  // Magnitude store and bin read port
  always_ff @(posedge clk) begin
    if (state == ST_MAG_WR) mag_mem[mag_i] <= mag_w;
    if (rd_acc) begin
      mag_q <= mag_mem[read_bin[HB-1:0]];
      rd_ok <= spectrum_ready && (32'(read_bin) < 32'(HALF));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) spectrum_ready <= 1'b0;
    else if ((state == ST_REPORT) && out_free) spectrum_ready <= 1'b1;
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (out_load) begin
      if (state == ST_REPORT) begin
        result_kind    <= KIND_PEAK;
        peak_found     <= found;
        peak_bin       <= found ? 11'(best_bin) : 11'd0;
        peak_magnitude <= found ? best_mag : 24'd0;
        bin_magnitude  <= 24'd0;
        bin_valid      <= 1'b0;
        dc_mean        <= dc;
      end else begin
        result_kind    <= KIND_BIN;
        peak_found     <= 1'b0;
        peak_bin       <= 11'd0;
        peak_magnitude <= 24'd0;
        bin_magnitude  <= rd_ok ? mag_q : 24'd0;
        bin_valid      <= rd_ok;
        dc_mean        <= 16'd0;
      end
    end
  end

  // ---------------- assertions ----------------
  a_one_write: assert property (@(posedge clk) disable iff (rst) !(v3 && vb))
    else $error("butterfly writes collide");
  a_cadence: assert property (@(posedge clk) disable iff (rst) bf_issue |-> !v1)
    else $error("butterfly issued on consecutive cycles");
  a_load_drained: assert property (@(posedge clk) disable iff (rst)
      (state == ST_FFT) |-> !ld_v)
    else $error("load write pending during transform");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
      32'(count) <= 32'(CNT_MAX))
    else $error("sample count past frame limit");
  a_report_clears: assert property (@(posedge clk) disable iff (rst)
      (out_load && (state == ST_REPORT)) |=> (count == '0) && spectrum_ready)
    else $error("frame state not cleared after report");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for fft_spectrum_peak_finder: a directed table, then random
// phases of frames and bin reads, checked against an in-bench spectrum predictor or the
// table's typed results. Depends on fspf_pkg and the fft_spectrum_peak_finder RTL.
`default_nettype none

module tb_top;
  import fspf_pkg::*;

  localparam int NPTS      = 1024;
  localparam int HALF      = NPTS / 2;
  localparam int LGN       = 10;
  localparam int TWB       = 16;
  localparam int MAX_SMP   = 2 * 4096;
  localparam int CYC_LIMIT = 6000000;
  localparam int SETTLE    = 60;

  typedef struct packed {
    logic        kind;
    logic        found;
    logic [10:0] pbin;
    logic [23:0] pmag;
    logic [23:0] bmag;
    logic        bvalid;
    logic [15:0] dcm;
  } report_t;

  typedef struct {
    logic        req;
    logic [15:0] word;
    logic        last;
    logic [11:0] rbin;
    bit          typed;
    report_t     res;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_stall;
  logic req_type = 0;
  logic [15:0] dma_word = '0;
  logic frame_last = 0;
  logic [11:0] read_bin = '0;
  logic out_valid, out_stall = 1;
  logic result_kind, peak_found, bin_valid;
  logic [10:0] peak_bin;
  logic [23:0] peak_magnitude, bin_magnitude;
  logic [15:0] dc_mean;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  fft_spectrum_peak_finder uut (.*);

  // Predictor state
  bit          cfg_dc;
  int unsigned cfg_start, cfg_end;
  logic [7:0]  smp_mem [NPTS];
  int unsigned smp_sum, smp_cnt;
  logic [23:0] mag_mem [HALF];
  bit          have_spectrum;
  longint      tw_c [HALF];
  longint      tw_s [HALF];

  report_t  pending_q [$];
  bit       failed = 0;
  bit       no_gaps = 0;
  bit       rx_hold = 0;
  int       cycles = 0;
  dir_row_t dir_tab [$];

  // Clock and watchdog
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("** fft_spectrum_peak_finder: FAILED **");
      $finish;
    end
  end

  function automatic logic [63:0] root64(logic [63:0] v_in);
    logic [63:0] v, r, b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Floor of (v / 2^sh + 1/2)
  function automatic longint rnd_half(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Build the twiddle table by half-angle rotations
  task automatic make_twiddles();
    longint ac [LGN+1];
    longint as_ [LGN+1];
    longint x, y, nx, ny, cq, sq, lim;
    lim = (longint'(1) <<< (TWB - 1)) - 1;
    ac[1] = -Q30_ONE;
    as_[1] = 0;
    for (int j = 2; j <= LGN; j++) begin
      ac[j]  = longint'(root64(64'(Q30_ONE + ac[j-1]) << 29));
      as_[j] = longint'(root64(64'(Q30_ONE - ac[j-1]) << 29));
    end
    for (int k = 0; k < HALF; k++) begin
      x = Q30_ONE;
      y = 0;
      for (int b = 0; b < LGN; b++) begin
        if ((k >> b) & 1) begin
          nx = rnd_half(x * ac[LGN-b] - y * as_[LGN-b], 30);
          ny = rnd_half(x * as_[LGN-b] + y * ac[LGN-b], 30);
          x = nx;
          y = ny;
        end
      end
      cq = rnd_half(x, 31 - TWB);
      sq = rnd_half(y, 31 - TWB);
      if (cq > lim) cq = lim;
      if (cq < -lim) cq = -lim;
      if (sq > lim) sq = lim;
      if (sq < -lim) sq = -lim;
      tw_c[k] = cq;
      tw_s[k] = sq;
    end
  endtask

  // Mean, transform, magnitudes and peak search for the finished frame
  function automatic report_t spectrum_report();
    longint re [NPTS];
    longint im [NPTS];
    longint dc, t, tr, ti, ar, ai, br, bi, c, s;
    logic [63:0] ure, uim, m;
    int unsigned used, r, lo, hi, half_len, step, k;
    report_t res;
    res = '0;
    res.kind = KIND_PEAK;
    dc = 0;
    if (smp_cnt != 0) dc = (longint'(smp_sum) * 256 + smp_cnt / 2) / smp_cnt;
    used = smp_cnt < NPTS ? smp_cnt : NPTS;
    for (int i = 0; i < NPTS; i++) begin
      re[i] = 0;
      im[i] = 0;
      if (i < used) re[i] = longint'(smp_mem[i]) * 256 - (cfg_dc ? dc : 0);
    end
    for (int i = 0; i < NPTS; i++) begin
      r = 0;
      for (int b = 0; b < LGN; b++) r |= ((i >> b) & 1) << (LGN - 1 - b);
      if (i < r) begin
        t = re[i]; re[i] = re[r]; re[r] = t;
      end
    end
    for (int len = 2; len <= NPTS; len <<= 1) begin
      half_len = len / 2;
      step = NPTS / len;
      for (int st = 0; st < NPTS; st += len) begin
        for (int mi = 0; mi < half_len; mi++) begin
          k = (mi * step) % HALF;
          c = tw_c[k];
          s = tw_s[k];
          ar = re[st+mi];
          ai = im[st+mi];
          br = re[st+mi+half_len];
          bi = im[st+mi+half_len];
          tr = rnd_half(br * c + bi * s, TWB - 1);
          ti = rnd_half(bi * c - br * s, TWB - 1);
          re[st+mi] = sat32(ar + tr);
          im[st+mi] = sat32(ai + ti);
          re[st+mi+half_len] = sat32(ar - tr);
          im[st+mi+half_len] = sat32(ai - ti);
        end
      end
    end
    for (int i = 0; i < HALF; i++) begin
      ure = re[i] < 0 ? 64'(-re[i]) : 64'(re[i]);
      uim = im[i] < 0 ? 64'(-im[i]) : 64'(im[i]);
      m = (root64(ure * ure + uim * uim) + 8) >> 4;
      mag_mem[i] = m > 64'd16777215 ? 24'hFFFFFF : m[23:0];
    end
    have_spectrum = 1;
    lo = cfg_start >= HALF ? HALF - 1 : cfg_start;
    hi = cfg_end >= HALF ? HALF - 1 : cfg_end;
    if (lo <= hi) begin
      res.found = 1;
      res.pbin = lo;
      res.pmag = mag_mem[lo];
      for (int i = lo + 1; i <= hi; i++) begin
        if (mag_mem[i] > res.pmag) begin
          res.pmag = mag_mem[i];
          res.pbin = i;
        end
      end
    end
    res.dcm = dc[15:0];
    smp_sum = 0;
    smp_cnt = 0;
    return res;
  endfunction

  // Advance the predictor by one accepted request; queue the result if any
  task automatic predict_request(logic req, logic [15:0] word, logic last, logic [11:0] rbin,
                                 bit typed, report_t typed_res);
    report_t res;
    bit      produced;
    res = '0;
    produced = 0;
    if (req == REQ_READ) begin
      res.kind = KIND_BIN;
      if (have_spectrum && rbin < HALF) begin
        res.bvalid = 1;
        res.bmag = mag_mem[rbin];
      end
      produced = 1;
    end else begin
      if (smp_cnt < MAX_SMP) begin
        for (int h = 0; h < 2; h++) begin
          if (smp_cnt < NPTS) smp_mem[smp_cnt] = word[8*h +: 8];
          smp_sum += word[8*h +: 8];
          smp_cnt++;
        end
      end
      if (last) begin
        res = spectrum_report();
        produced = 1;
      end
    end
    if (produced) pending_q.push_back(typed ? typed_res : res);
  endtask

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send(logic req, logic [15:0] word, logic last, logic [11:0] rbin,
                      bit typed = 0, report_t typed_res = '0);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1;
    req_type   <= req;
    dma_word   <= word;
    frame_last <= last;
    read_bin   <= rbin;
    do @(posedge clk); while (in_stall);
    predict_request(req, word, last, rbin, typed, typed_res);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    case (idx)
      REG_DC_REMOVE:    cfg_dc = val[0];
      REG_SEARCH_START: cfg_start = val[11:0];
      REG_SEARCH_END:   cfg_end = val[11:0];
      default: ;
    endcase
  endtask

  // Drain all results, then let any trailing work finish
  task automatic wait_drained();
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic dir_row_t row(logic req, logic [15:0] word, logic last,
                                   logic [11:0] rbin, bit typed = 0, report_t res = '0);
    dir_row_t d;
    d.req = req; d.word = word; d.last = last; d.rbin = rbin;
    d.typed = typed; d.res = res;
    return d;
  endfunction

  // Receiver: random stall before each transaction, with one long hold on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 12);
      if (rx_hold) begin
        rx_hold = 0;
        n = 700;
      end
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    report_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{result_kind, peak_found, peak_bin, peak_magnitude, bin_magnitude,
              bin_valid, dc_mean};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        failed = 1;
      end else begin
        want = pending_q.pop_front();
        if (got.kind != want.kind) begin
          $display("%0t: result_kind exp %0d got %0d", $time, want.kind, got.kind);
          failed = 1;
        end
        if (got.found != want.found) begin
          $display("%0t: peak_found exp %0d got %0d", $time, want.found, got.found);
          failed = 1;
        end
        if (got.pbin != want.pbin) begin
          $display("%0t: peak_bin exp %0d got %0d", $time, want.pbin, got.pbin);
          failed = 1;
        end
        if (got.pmag != want.pmag) begin
          $display("%0t: peak_magnitude exp %0d got %0d", $time, want.pmag, got.pmag);
          failed = 1;
        end
        if (got.bmag != want.bmag) begin
          $display("%0t: bin_magnitude exp %0d got %0d", $time, want.bmag, got.bmag);
          failed = 1;
        end
        if (got.bvalid != want.bvalid) begin
          $display("%0t: bin_valid exp %0d got %0d", $time, want.bvalid, got.bvalid);
          failed = 1;
        end
        if (got.dcm != want.dcm) begin
          $display("%0t: dc_mean exp %h got %h", $time, want.dcm, got.dcm);
          failed = 1;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int len, nreads, wleft, rleft, wi;
    bit pattern;
    logic [7:0] s0, s1;
    make_twiddles();
    cfg_dc = 1;
    cfg_start = 0;
    cfg_end = 511;
    smp_sum = 0;
    smp_cnt = 0;
    have_spectrum = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: no-spectrum and bad reads, flat frames at both extremes, mixed frame
    dir_tab.push_back(row(REQ_READ, 16'h0000, 0, 12'd0, 1, '{KIND_BIN, 0, 0, 0, 0, 0, 0}));
    dir_tab.push_back(row(REQ_READ, 16'hFFFF, 1, 12'hFFF, 1, '{KIND_BIN, 0, 0, 0, 0, 0, 0}));
    dir_tab.push_back(row(REQ_SAMPLE, 16'h0000, 1, 12'd0, 1,
                          '{KIND_PEAK, 1, 0, 0, 0, 0, 16'h0000}));
    dir_tab.push_back(row(REQ_SAMPLE, 16'hFFFF, 1, 12'hFFF, 1,
                          '{KIND_PEAK, 1, 0, 0, 0, 0, 16'hFF00}));
    dir_tab.push_back(row(REQ_READ, 16'h0000, 0, 12'd511, 1, '{KIND_BIN, 0, 0, 0, 0, 1, 0}));
    dir_tab.push_back(row(REQ_READ, 16'h0000, 0, 12'd512, 1, '{KIND_BIN, 0, 0, 0, 0, 0, 0}));
    dir_tab.push_back(row(REQ_READ, 16'h0000, 1, 12'hFFF, 1, '{KIND_BIN, 0, 0, 0, 0, 0, 0}));
    dir_tab.push_back(row(REQ_SAMPLE, 16'h00FF, 0, 12'd0));
    dir_tab.push_back(row(REQ_SAMPLE, 16'hFF00, 0, 12'hFFF));
    dir_tab.push_back(row(REQ_READ, 16'h5555, 0, 12'd0));
    dir_tab.push_back(row(REQ_SAMPLE, 16'h807F, 0, 12'd0));
    dir_tab.push_back(row(REQ_SAMPLE, 16'h00FF, 0, 12'd0));
    dir_tab.push_back(row(REQ_SAMPLE, 16'hFF00, 0, 12'd0));
    dir_tab.push_back(row(REQ_SAMPLE, 16'h1234, 0, 12'd0));
    dir_tab.push_back(row(REQ_SAMPLE, 16'hAA55, 1, 12'd0));
    dir_tab.push_back(row(REQ_READ, 16'h0000, 0, 12'd0));
    dir_tab.push_back(row(REQ_READ, 16'h0000, 0, 12'd1));
    dir_tab.push_back(row(REQ_READ, 16'h0000, 0, 12'd2));
    dir_tab.push_back(row(REQ_READ, 16'h0000, 0, 12'd255));
    dir_tab.push_back(row(REQ_READ, 16'h0000, 0, 12'd511));
    foreach (dir_tab[i])
      send(dir_tab[i].req, dir_tab[i].word, dir_tab[i].last, dir_tab[i].rbin,
           dir_tab[i].typed, dir_tab[i].res);
    wait_drained();

    // Random phases: new settings, one frame, bin reads mixed in
    for (int ph = 0; ph < 13; ph++) begin
      case (ph)
        0: begin reg_write(REG_DC_REMOVE, 0); reg_write(REG_SEARCH_START, 0);
                 reg_write(REG_SEARCH_END, 4095); end
        1: begin reg_write(REG_DC_REMOVE, 1); reg_write(REG_SEARCH_START, 4095);
                 reg_write(REG_SEARCH_END, 4095); end
        2: begin reg_write(REG_SEARCH_START, 10); reg_write(REG_SEARCH_END, 3); end
        3: begin reg_write(REG_SEARCH_START, 0); reg_write(REG_SEARCH_END, 0); end
        default: begin
          reg_write(REG_DC_REMOVE, $urandom_range(0, 1));
          reg_write(REG_SEARCH_START, $urandom_range(0, 1) ? $urandom_range(0, 4095)
                                                          : $urandom_range(0, 40));
          reg_write(REG_SEARCH_END, $urandom_range(0, 1) ? $urandom_range(0, 4095)
                                                        : $urandom_range(200, 600));
        end
      endcase
      no_gaps = (ph % 4 == 1);
      pattern = $urandom_range(0, 1);
      case (ph)
        5: len = 560;
        default: len = $urandom_range(1, 16);
      endcase
      if (ph == 6) no_gaps = 1;

      // Fill the output path while the receiver holds off
      if (ph == 3) begin
        rx_hold = 1;
        no_gaps = 1;
        for (int i = 0; i < 60; i++) send(REQ_READ, $urandom, $urandom_range(0, 1),
                                          $urandom_range(0, 1) ? $urandom_range(0, 511)
                                                               : $urandom_range(0, 4095));
        no_gaps = 0;
      end

      nreads = (len > 70) ? 20 : 35 - len;
      wleft = len;
      rleft = nreads;
      wi = 0;
      while (wleft > 0 || rleft > 0) begin
        if (rleft > 0 && (wleft == 0 || $urandom_range(0, len + nreads - 1) < nreads)) begin
          send(REQ_READ, $urandom, $urandom_range(0, 1),
               $urandom_range(0, 3) != 0 ? $urandom_range(0, 511) : $urandom_range(0, 4095));
          rleft--;
        end else if (wleft > 0) begin
          if (pattern) begin
            s0 = ((2 * wi) % 8 < 4) ? 8'd200 + $urandom_range(0, 55) : $urandom_range(0, 50);
            s1 = ((2 * wi + 1) % 8 < 4) ? 8'd200 + $urandom_range(0, 55)
                                        : $urandom_range(0, 50);
          end else begin
            s0 = $urandom;
            s1 = $urandom;
          end
          // The frame end always goes last so reads afterward see the new spectrum
          if (wleft == 1 && rleft > 0) begin
            while (rleft > 0) begin
              send(REQ_READ, $urandom, $urandom_range(0, 1), $urandom_range(0, 4095));
              rleft--;
            end
          end
          send(REQ_SAMPLE, {s1, s0}, wleft == 1, $urandom);
          wleft--;
          wi++;
        end
      end
      for (int i = 0; i < 8; i++) send(REQ_READ, $urandom, 0, $urandom_range(0, 511));
      wait_drained();
    end
    no_gaps = 0;

    if (!failed) begin
      $display("** fft_spectrum_peak_finder: PASSED **");
    end else begin
      $display("** fft_spectrum_peak_finder: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/fspf_pkg.sv
hw/rtl/fft_spectrum_peak_finder.sv
tb/tb_top.sv
